FILE: hw/rtl/voice_activity_segmenter_defines.svh
// assertion macros shared by the segmenter checker
// no dependencies
`ifndef VOICE_ACTIVITY_SEGMENTER_DEFINES_SVH
`define VOICE_ACTIVITY_SEGMENTER_DEFINES_SVH

// implication checked in the next cycle, masked while in reset
`define VAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("segmenter assertion failed");

// implication checked in the next cycle, also active during reset
`define VAS_ASSERT_RESET(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("segmenter reset assertion failed");

`endif

FILE: hw/rtl/vas_pkg.sv
// shared types, constants and helpers of the voice activity segmenter
// no dependencies
package vas_pkg;

  localparam int CNT_W = 32;
  localparam int CMP_W = (CNT_W > 32) ? CNT_W : 32;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [15:0] LOW_BAND_Q15 = 16'd4915;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CMP_W-1:0] cmp_t;

  localparam logic [2:0] REG_THRESHOLD   = 3'd0;
  localparam logic [2:0] REG_WINDOW      = 3'd1;
  localparam logic [2:0] REG_MIN_SILENCE = 3'd2;
  localparam logic [2:0] REG_LONG_SILENCE = 3'd3;
  localparam logic [2:0] REG_MIN_SPEECH  = 3'd4;
  localparam logic [2:0] REG_MAX_SPEECH  = 3'd5;

  localparam logic OP_WINDOW = 1'b0;
  localparam logic OP_END    = 1'b1;

  typedef enum logic [1:0] {
    CAUSE_SILENCE = 2'd0,
    CAUSE_SPLIT   = 2'd1,
    CAUSE_CUT     = 2'd2,
    CAUSE_END     = 2'd3
  } cause_t;

  typedef struct packed {
    logic [15:0] threshold;
    logic [12:0] window;
    logic [31:0] min_silence;
    logic [31:0] long_silence;
    logic [31:0] min_speech;
    logic [31:0] max_speech;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic        speech;
    logic        silence;
    logic [31:0] audio_length;
  } item_t;

  function automatic logic [31:0] to_pos(cnt_t x);
    cmp_t w;
    w = cmp_t'(x);
    return w[31:0];
  endfunction

endpackage

FILE: hw/rtl/voice_activity_segmenter.sv
// voice activity segmenter top level: config registers, front, queue, back
// an input beat passes the front register, the queue memory and the back result register
// throughput: one item per cycle while the result output is not stalled; the back stage updates its state once per item
// reset: synchronous active low; clears segment state, queue and output valid,
// and loads default register values
module voice_activity_segmenter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [15:0] in_speech_prob,
  input  logic [31:0] in_audio_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_segment_start,
  output logic [31:0] out_segment_end,
  output logic [1:0]  out_close_cause,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  vas_pkg::cfg_t  cfg_r, cfg_nxt;
  logic           fr_valid, fr_ready, q_valid, q_ready;
  vas_pkg::item_t fr_item, q_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        vas_pkg::REG_THRESHOLD:    cfg_nxt.threshold    = cfg_data[15:0];
        vas_pkg::REG_WINDOW:       cfg_nxt.window       = cfg_data[12:0];
        vas_pkg::REG_MIN_SILENCE:  cfg_nxt.min_silence  = cfg_data;
        vas_pkg::REG_LONG_SILENCE: cfg_nxt.long_silence = cfg_data;
        vas_pkg::REG_MIN_SPEECH:   cfg_nxt.min_speech   = cfg_data;
        vas_pkg::REG_MAX_SPEECH:   cfg_nxt.max_speech   = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold    <= 16'd16384;
      cfg_r.window       <= 13'd512;
      cfg_r.min_silence  <= 32'd0;
      cfg_r.long_silence <= 32'd1568;
      cfg_r.min_speech   <= 32'd512;
      cfg_r.max_speech   <= 32'hFFFF_FFFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  vas_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_speech_prob  (in_speech_prob),
    .in_audio_length (in_audio_length),
    .fr_valid        (fr_valid),
    .fr_ready        (fr_ready),
    .fr_item         (fr_item)
  );

  vas_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_item  (fr_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  vas_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_item            (q_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_segment_start (out_segment_start),
    .out_segment_end   (out_segment_end),
    .out_close_cause   (out_close_cause)
  );

endmodule

FILE: hw/rtl/vas_front.sv
// front stage: accepts input beats and classifies each window
// depends on vas_pkg
module vas_front (
  input  logic                clk,
  input  logic                rst_n,
  input  vas_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_opcode,
  input  logic [15:0]         in_speech_prob,
  input  logic [31:0]         in_audio_length,
  output logic                fr_valid,
  input  logic                fr_ready,
  output vas_pkg::item_t      fr_item
);

  logic           v_r, v_nxt;
  vas_pkg::item_t item_r, item_nxt;
  logic           low_ok;

  assign in_ready = !v_r || fr_ready;
  assign low_ok   = cfg.threshold >= vas_pkg::LOW_BAND_Q15;

  always_comb begin
    item_nxt = item_r;
    v_nxt    = v_r;
    if (fr_ready) begin
      v_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      v_nxt                 = 1'b1;
      item_nxt.op           = in_opcode;
      item_nxt.speech       = in_speech_prob >= cfg.threshold;
      item_nxt.silence      = low_ok &&
                              (in_speech_prob < (cfg.threshold - vas_pkg::LOW_BAND_Q15));
      item_nxt.audio_length = in_audio_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    item_r <= item_nxt;
  end

  assign fr_valid = v_r;
  assign fr_item  = item_r;

endmodule

FILE: hw/rtl/vas_queue.sv
// short queue of classified items between front and back
// depends on vas_pkg
module vas_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  vas_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output vas_pkg::item_t rd_item
);

  vas_pkg::item_t                    mem_r [vas_pkg::QDEPTH];
  logic [vas_pkg::QPTR_W-1:0]        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [vas_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;
  logic                              push, pop;

  assign wr_ready = cnt_r != vas_pkg::QCNT_W'(vas_pkg::QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == vas_pkg::QPTR_W'(vas_pkg::QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == vas_pkg::QPTR_W'(vas_pkg::QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule

FILE: hw/rtl/vas_back.sv
// back stage: segment state update and result output register
// depends on vas_pkg
module vas_back (
  input  logic                clk,
  input  logic                rst_n,
  input  vas_pkg::cfg_t       cfg,
  input  logic                q_valid,
  output logic                q_ready,
  input  vas_pkg::item_t      q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_segment_start,
  output logic [31:0]         out_segment_end,
  output logic [1:0]          out_close_cause
);

  logic            in_r, in_nxt;
  vas_pkg::cnt_t   cnt_r, cnt_nxt;
  vas_pkg::cnt_t   os_r, os_nxt;
  vas_pkg::cnt_t   te_r, te_nxt;
  vas_pkg::cnt_t   se_r, se_nxt;
  vas_pkg::cnt_t   rs_r, rs_nxt;
  logic            ov_r, ov_nxt;
  logic [31:0]     st_r, st_nxt, en_r, en_nxt;
  vas_pkg::cause_t cause_r, cause_nxt;

  vas_pkg::cnt_t   n, run_len, te_eff, silent, seg_len;
  logic            take, max_hit;

  assign take    = q_valid && (!ov_r || out_ready);
  assign q_ready = !ov_r || out_ready;

  assign n       = cnt_r + vas_pkg::cnt_t'(cfg.window);
  assign run_len = n - os_r;
  assign te_eff  = (te_r == '0) ? n : te_r;
  assign silent  = n - te_eff;
  assign seg_len = te_eff - os_r;
  assign max_hit = in_r && (cfg.max_speech != '1) &&
                   (vas_pkg::cmp_t'(run_len) > vas_pkg::cmp_t'(cfg.max_speech));

  always_comb begin
    in_nxt    = in_r;
    cnt_nxt   = cnt_r;
    os_nxt    = os_r;
    te_nxt    = te_r;
    se_nxt    = se_r;
    rs_nxt    = rs_r;
    ov_nxt    = ov_r;
    st_nxt    = st_r;
    en_nxt    = en_r;
    cause_nxt = cause_r;
    if (out_ready) begin
      ov_nxt = 1'b0;
    end
    if (take) begin
      ov_nxt = 1'b0;
      if (q_item.op == vas_pkg::OP_END) begin
        ov_nxt    = in_r;
        st_nxt    = vas_pkg::to_pos(os_r);
        en_nxt    = q_item.audio_length;
        cause_nxt = vas_pkg::CAUSE_END;
        in_nxt    = 1'b0;
        cnt_nxt   = '0;
        os_nxt    = '0;
        te_nxt    = '0;
        se_nxt    = '0;
        rs_nxt    = '0;
      end else begin
        cnt_nxt = n;
        if (q_item.speech) begin
          if (te_r != '0) begin
            te_nxt = '0;
            if (rs_r < se_r) begin
              rs_nxt = cnt_r;
            end
          end
          if (!in_r) begin
            in_nxt = 1'b1;
            os_nxt = cnt_r;
          end
        end else if (max_hit) begin
          ov_nxt = 1'b1;
          st_nxt = vas_pkg::to_pos(os_r);
          if (se_r != '0) begin
            en_nxt    = vas_pkg::to_pos(se_r);
            cause_nxt = vas_pkg::CAUSE_SPLIT;
            if (rs_r < se_r) begin
              in_nxt = 1'b0;
              os_nxt = '0;
            end else begin
              os_nxt = rs_r;
            end
          end else begin
            en_nxt    = vas_pkg::to_pos(n);
            cause_nxt = vas_pkg::CAUSE_CUT;
            in_nxt    = 1'b0;
            os_nxt    = '0;
          end
          te_nxt = '0;
          se_nxt = '0;
          rs_nxt = '0;
        end else if (q_item.silence && in_r) begin
          te_nxt = te_eff;
          if (vas_pkg::cmp_t'(silent) > vas_pkg::cmp_t'(cfg.long_silence)) begin
            se_nxt = te_eff;
          end
          if ((vas_pkg::cmp_t'(silent) >= vas_pkg::cmp_t'(cfg.min_silence)) &&
              (vas_pkg::cmp_t'(seg_len) > vas_pkg::cmp_t'(cfg.min_speech))) begin
            ov_nxt    = 1'b1;
            st_nxt    = vas_pkg::to_pos(os_r);
            en_nxt    = vas_pkg::to_pos(te_eff);
            cause_nxt = vas_pkg::CAUSE_SILENCE;
            in_nxt    = 1'b0;
            os_nxt    = '0;
            te_nxt    = '0;
            se_nxt    = '0;
            rs_nxt    = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r  <= 1'b0;
      cnt_r <= '0;
      os_r  <= '0;
      te_r  <= '0;
      se_r  <= '0;
      rs_r  <= '0;
      ov_r  <= 1'b0;
    end else begin
      in_r  <= in_nxt;
      cnt_r <= cnt_nxt;
      os_r  <= os_nxt;
      te_r  <= te_nxt;
      se_r  <= se_nxt;
      rs_r  <= rs_nxt;
      ov_r  <= ov_nxt;
    end
    st_r    <= st_nxt;
    en_r    <= en_nxt;
    cause_r <= cause_nxt;
  end

  assign out_valid         = ov_r;
  assign out_segment_start = st_r;
  assign out_segment_end   = en_r;
  assign out_close_cause   = cause_r;

endmodule

FILE: hw/rtl/vas_checker.sv
// port-level checks of the voice activity segmenter, bound to the top level
// depends on voice_activity_segmenter_defines.svh
`include "voice_activity_segmenter_defines.svh"

module vas_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_segment_start,
  input logic [31:0] out_segment_end,
  input logic [1:0]  out_close_cause
);

  logic [65:0] out_payload;

  assign out_payload = {out_segment_start, out_segment_end, out_close_cause};

  // a stalled result beat stays
  `VAS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // a stalled result beat keeps its payload
  `VAS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_payload))

  // reset empties the output register
  `VAS_ASSERT_RESET(a_rst_out, clk, !rst_n, !out_valid)

  // reset leaves the front ready for a beat
  `VAS_ASSERT_RESET(a_rst_in, clk, !rst_n, in_ready)

endmodule

bind voice_activity_segmenter vas_checker u_vas_checker (.*);
